// ----- sv/pab_pkg.sv -----
`timescale 1ns / 1ps

package pab_pkg;

	typedef logic [7:0]       chan_t;
	typedef logic [3:0][7:0]  rgba_t;   // [0] red, [1] green, [2] blue, [3] alpha
	typedef logic [3:0][15:0] prod_t;   // per-channel c*f + 127

	localparam int unsigned CH_ALPHA = 3;

	// factor modes
	localparam logic [3:0] FM_ZERO        = 4'd0;
	localparam logic [3:0] FM_ONE         = 4'd1;
	localparam logic [3:0] FM_SRC_COL     = 4'd2;
	localparam logic [3:0] FM_INV_SRC_COL = 4'd3;
	localparam logic [3:0] FM_SRC_ALPHA   = 4'd4;
	localparam logic [3:0] FM_INV_SRC_A   = 4'd5;
	localparam logic [3:0] FM_DST_ALPHA   = 4'd6;
	localparam logic [3:0] FM_INV_DST_A   = 4'd7;
	localparam logic [3:0] FM_DST_COL     = 4'd8;
	localparam logic [3:0] FM_INV_DST_COL = 4'd9;
	localparam logic [3:0] FM_ALPHA_SAT   = 4'd10;
	localparam logic [3:0] FM_CONST       = 4'd11;
	localparam logic [3:0] FM_INV_CONST   = 4'd12;

	// combine ops
	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_SUB     = 3'd1;
	localparam logic [2:0] OP_REV_SUB = 3'd2;
	localparam logic [2:0] OP_MIN     = 3'd3;
	localparam logic [2:0] OP_MAX     = 3'd4;

	// register indexes
	localparam logic [2:0] CFG_ENABLE   = 3'd0;
	localparam logic [2:0] CFG_SRC_MODE = 3'd1;
	localparam logic [2:0] CFG_DST_MODE = 3'd2;
	localparam logic [2:0] CFG_OP       = 3'd3;
	localparam logic [2:0] CFG_CONST    = 3'd4;

	typedef struct packed {
		logic        enable;
		logic [3:0]  src_mode;
		logic [3:0]  dst_mode;
		logic [2:0]  op;
		logic [31:0] const_col;
	} cfg_t;

endpackage

// ----- sv/pab_factor.sv -----
`timescale 1ns / 1ps

// Blend factor select for all four channels, one mode.
module pab_factor (
	input  logic [3:0]     mode,
	input  logic [31:0]    const_col,
	input  pab_pkg::rgba_t src,
	input  pab_pkg::rgba_t dst,
	output pab_pkg::rgba_t factor
);

	pab_pkg::chan_t sat;
	pab_pkg::rgba_t cc;

	// min(src alpha, 1 - dst alpha)
	assign sat = (src[pab_pkg::CH_ALPHA] < ~dst[pab_pkg::CH_ALPHA]) ?
		src[pab_pkg::CH_ALPHA] : ~dst[pab_pkg::CH_ALPHA];

	for (genvar ch = 0; ch < 4; ch++) begin : g_ch
		assign cc[ch] = const_col[31 - 8 * ch -: 8];

		always_comb begin
			unique case (mode)
				pab_pkg::FM_ZERO:        factor[ch] = 8'd0;
				pab_pkg::FM_ONE:         factor[ch] = 8'd255;
				pab_pkg::FM_SRC_COL:     factor[ch] = src[ch];
				pab_pkg::FM_INV_SRC_COL: factor[ch] = ~src[ch];
				pab_pkg::FM_SRC_ALPHA:   factor[ch] = src[pab_pkg::CH_ALPHA];
				pab_pkg::FM_INV_SRC_A:   factor[ch] = ~src[pab_pkg::CH_ALPHA];
				pab_pkg::FM_DST_ALPHA:   factor[ch] = dst[pab_pkg::CH_ALPHA];
				pab_pkg::FM_INV_DST_A:   factor[ch] = ~dst[pab_pkg::CH_ALPHA];
				pab_pkg::FM_DST_COL:     factor[ch] = dst[ch];
				pab_pkg::FM_INV_DST_COL: factor[ch] = ~dst[ch];
				pab_pkg::FM_ALPHA_SAT:   factor[ch] = (ch == pab_pkg::CH_ALPHA) ? 8'd255 : sat;
				pab_pkg::FM_CONST:       factor[ch] = cc[ch];
				pab_pkg::FM_INV_CONST:   factor[ch] = ~cc[ch];
				default:                 factor[ch] = 8'd0;
			endcase
		end
	end

endmodule

// ----- sv/pab_div255.sv -----
`timescale 1ns / 1ps

// floor(x / 255) per lane as (x + (x >> 8) + 1) >> 8, exact for x below 65280 (8-bit quotient).
module pab_div255 (
	input  pab_pkg::prod_t x,
	output pab_pkg::rgba_t q
);

	logic [3:0][16:0] t;

	for (genvar ch = 0; ch < 4; ch++) begin : g_ch
		assign t[ch] = {1'b0, x[ch]} + {9'd0, x[ch][15:8]} + 17'd1;
		assign q[ch] = t[ch][15:8];
	end

endmodule

// ----- sv/pab_combine.sv -----
`timescale 1ns / 1ps

// Final combine of scaled source and destination; bypass when blending is off.
module pab_combine (
	input  pab_pkg::cfg_t  cfg,
	input  pab_pkg::rgba_t src,
	input  pab_pkg::rgba_t sc,
	input  pab_pkg::rgba_t dc,
	output pab_pkg::rgba_t result
);

	for (genvar ch = 0; ch < 4; ch++) begin : g_ch
		logic [8:0] sum;
		logic       a_gt_b;
		logic       a_lt_b;
		pab_pkg::chan_t blended;

		assign sum    = {1'b0, sc[ch]} + {1'b0, dc[ch]};
		assign a_gt_b = sc[ch] > dc[ch];
		assign a_lt_b = sc[ch] < dc[ch];

		always_comb begin
			case (cfg.op)
				pab_pkg::OP_SUB:     blended = a_gt_b ? sc[ch] - dc[ch] : 8'd0;
				pab_pkg::OP_REV_SUB: blended = a_lt_b ? dc[ch] - sc[ch] : 8'd0;
				pab_pkg::OP_MIN:     blended = a_lt_b ? sc[ch] : dc[ch];
				pab_pkg::OP_MAX:     blended = a_gt_b ? sc[ch] : dc[ch];
				default:             blended = sum[8] ? 8'd255 : sum[7:0]; // add, unused ops
			endcase
		end

		assign result[ch] = cfg.enable ? blended : src[ch];
	end

endmodule

// ----- sv/pixel_alpha_blend_unit_top.sv -----
// Throughput: one pixel per cycle while in_stall is low; four register stages (factor
//   select, multiply, divide by 255, combine into the output register) advance
//   independently, and an accepted input reaches out_valid from the last of them.
// Stalls collapse bubbles: in_stall rises only when all four stages hold data.
// Reset (arst_n low, asynchronous): stage valids clear, config registers take their defaults.
`timescale 1ns / 1ps

module pixel_alpha_blend_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  src_red,
	input  logic [7:0]  src_green,
	input  logic [7:0]  src_blue,
	input  logic [7:0]  src_alpha,
	input  logic [7:0]  dst_red,
	input  logic [7:0]  dst_green,
	input  logic [7:0]  dst_blue,
	input  logic [7:0]  dst_alpha,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha
);

	pab_pkg::cfg_t cfg_q;

	// Register file. Writes must arrive only while the pipe is empty (the block does not
	// enforce this), since every stage reads the live values directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable    <= 1'b0;
			cfg_q.src_mode  <= pab_pkg::FM_ONE;
			cfg_q.dst_mode  <= pab_pkg::FM_ZERO;
			cfg_q.op        <= pab_pkg::OP_ADD;
			cfg_q.const_col <= 32'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pab_pkg::CFG_ENABLE:   cfg_q.enable    <= cfg_data[0];
				pab_pkg::CFG_SRC_MODE: cfg_q.src_mode  <= cfg_data[3:0];
				pab_pkg::CFG_DST_MODE: cfg_q.dst_mode  <= cfg_data[3:0];
				pab_pkg::CFG_OP:       cfg_q.op        <= cfg_data[2:0];
				pab_pkg::CFG_CONST:    cfg_q.const_col <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stage advance. A stage loads when it is empty or its successor
	// loads; the output register loads when empty or not stalled.
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4      = !v_s4 || !out_stall;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: capture pixels and both factor sets.
	// ---------------------------------------------------------------
	pab_pkg::rgba_t src_px, dst_px, sf, df;
	pab_pkg::rgba_t src_s1, dst_s1, sf_s1, df_s1;

	assign src_px = {src_alpha, src_blue, src_green, src_red};
	assign dst_px = {dst_alpha, dst_blue, dst_green, dst_red};

	pab_factor u_src_factor (
		.mode      (cfg_q.src_mode),
		.const_col (cfg_q.const_col),
		.src       (src_px),
		.dst       (dst_px),
		.factor    (sf)
	);

	pab_factor u_dst_factor (
		.mode      (cfg_q.dst_mode),
		.const_col (cfg_q.const_col),
		.src       (src_px),
		.dst       (dst_px),
		.factor    (df)
	);

	always_ff @(posedge clk) begin
		if (en1) begin
			src_s1 <= src_px;
			dst_s1 <= dst_px;
			sf_s1  <= sf;
			df_s1  <= df;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: 8x8 products with the rounding bias folded in.
	// Max value 255*255 + 127 fits 16 bits.
	// ---------------------------------------------------------------
	pab_pkg::prod_t sp_s2, dp_s2;
	pab_pkg::rgba_t src_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int ch = 0; ch < 4; ch++) begin
				sp_s2[ch] <= ({8'd0, src_s1[ch]} * {8'd0, sf_s1[ch]}) + 16'd127;
				dp_s2[ch] <= ({8'd0, dst_s1[ch]} * {8'd0, df_s1[ch]}) + 16'd127;
			end
			src_s2 <= src_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: divide by 255 (shift-add, no divider).
	// ---------------------------------------------------------------
	pab_pkg::rgba_t sq, dq;
	pab_pkg::rgba_t sq_s3, dq_s3, src_s3;

	pab_div255 u_src_div (.x(sp_s2), .q(sq));
	pab_div255 u_dst_div (.x(dp_s2), .q(dq));

	always_ff @(posedge clk) begin
		if (en3) begin
			sq_s3  <= sq;
			dq_s3  <= dq;
			src_s3 <= src_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: combine into the output register.
	// ---------------------------------------------------------------
	pab_pkg::rgba_t res, res_s4;

	pab_combine u_combine (
		.cfg    (cfg_q),
		.src    (src_s3),
		.sc     (sq_s3),
		.dc     (dq_s3),
		.result (res)
	);

	always_ff @(posedge clk) begin
		if (en4) res_s4 <= res;
	end

	assign out_valid = v_s4;
	assign out_red   = res_s4[0];
	assign out_green = res_s4[1];
	assign out_blue  = res_s4[2];
	assign out_alpha = res_s4[3];

endmodule

// ----- sv/pab_checker.sv -----
`timescale 1ns / 1ps

module pab_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [7:0] out_alpha
);

	// pipe empties in reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// input backs up only behind a stalled, full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without stalled output");

	// accepted input reaches out_valid through the pipeline when the output side never stalls
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing after pipeline latency");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_alpha)))
		else $error("stalled output transaction changed");

endmodule

bind pixel_alpha_blend_unit_top pab_checker u_pab_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_red   (out_red),
	.out_green (out_green),
	.out_blue  (out_blue),
	.out_alpha (out_alpha)
);
